[design/rrts_pkg.sv]
// ============================================================================
// rrts_pkg
// Shared types and codes for the round-robin thread slot scheduler: request
// modes, result status codes and the command/status bundles that pass
// between the controller and the datapath.
// ============================================================================
package rrts_pkg;

    localparam int MODE_W      = 3;
    localparam int CHAR_W      = 8;
    localparam int SLEEP_IN_W  = 32;
    localparam int SLOT_OUT_W  = 5;
    localparam int CNT_OUT_W   = 6;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 40;

    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_KILL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WAIT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CHAR   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RUN     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE_WOKEN = 2'd3;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_RD_RHEAD,
        OP_TICK_ADV,
        OP_CRT_CLEAR,
        OP_CRT_SCAN,
        OP_KILL_TAKE,
        OP_WAIT_TAKE,
        OP_RD_LINKS,
        OP_REM_CLR,
        OP_REM_LINK,
        OP_APP_ONE,
        OP_APP_TAIL,
        OP_APP_HEAD,
        OP_CHR_START,
        OP_CHR_STEP,
        OP_CHR_HIT,
        OP_FINISH
    } dp_op_t;

    typedef enum logic {
        RING_READY,
        RING_WAIT
    } ring_t;

    typedef struct packed {
        dp_op_t                op;
        ring_t                 ring;
        logic [STATUS_W-1:0]   st;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              ready_zero;
        logic              ready_one;
        logic              wait_zero;
        logic              wait_one;
        logic              free_hit;
        logic              free_last;
        logic              sleep_zero;
        logic              walk_last;
        logic              out_busy;
    } dp_stat_t;

endpackage

[design/rrts_ram.sv]
// ============================================================================
// rrts_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/rrts_ctrl.sv]
// ============================================================================
// rrts_ctrl
// Sequencer of the scheduler. It takes one request word, walks through the
// steps of the selected operation and hands each step to the datapath as a
// command.
// ============================================================================
module rrts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rrts_pkg::dp_stat_t stat,
    output rrts_pkg::dp_cmd_t  cmd
);
    import rrts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TICK_ADV,
        S_CRT_SCAN,
        S_REM_RD,
        S_REM_WR,
        S_APP_CHK,
        S_APP_HEAD,
        S_CHR_WALK,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    ring_t               ring_reg, ring_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    dp_op_t              op;
    logic                sel_zero, sel_one;
    state_t              rem_state;
    ring_t               rem_ring;

    always_comb
    begin
        sel_zero = (ring_reg == RING_READY) ? stat.ready_zero : stat.wait_zero;
        sel_one  = (ring_reg == RING_READY) ? stat.ready_one  : stat.wait_one;

        // Where to go once a slot has left its ring.
        case (stat.mode)
            MODE_WAIT:
            begin
                rem_state = S_APP_CHK;
                rem_ring  = RING_WAIT;
            end
            MODE_CHAR:
            begin
                rem_state = S_APP_CHK;
                rem_ring  = RING_READY;
            end
            default:
            begin
                rem_state = S_DONE;
                rem_ring  = ring_reg;
            end
        endcase

        state_next = state_reg;
        ring_next  = ring_reg;
        st_next    = st_reg;
        op         = OP_NOP;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op         = OP_ACCEPT;
                    st_next    = ST_OK;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.mode)
                    MODE_TICK:
                    begin
                        if (stat.ready_zero)
                        begin
                            st_next    = ST_NO_RUN;
                            state_next = S_DONE;
                        end
                        else if (stat.ready_one)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            op         = OP_RD_RHEAD;
                            state_next = S_TICK_ADV;
                        end
                    end
                    MODE_CREATE:
                    begin
                        op         = OP_CRT_CLEAR;
                        state_next = S_CRT_SCAN;
                    end
                    MODE_KILL, MODE_WAIT:
                    begin
                        if (stat.ready_zero)
                        begin
                            st_next    = ST_NO_RUN;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            op         = (stat.mode == MODE_KILL) ? OP_KILL_TAKE : OP_WAIT_TAKE;
                            ring_next  = RING_READY;
                            state_next = S_REM_RD;
                        end
                    end
                    MODE_CHAR:
                    begin
                        if (stat.wait_zero)
                        begin
                            st_next    = ST_NONE_WOKEN;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            op         = OP_CHR_START;
                            state_next = S_CHR_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_TICK_ADV:
            begin
                op         = OP_TICK_ADV;
                state_next = S_DONE;
            end
            S_CRT_SCAN:
            begin
                op = OP_CRT_SCAN;
                if (stat.free_hit)
                begin
                    ring_next  = RING_READY;
                    state_next = S_APP_CHK;
                end
                else if (stat.free_last)
                begin
                    st_next    = ST_NO_FREE;
                    state_next = S_DONE;
                end
            end
            S_REM_RD:
            begin
                if (sel_one)
                begin
                    op         = OP_REM_CLR;
                    ring_next  = rem_ring;
                    state_next = rem_state;
                end
                else
                begin
                    op         = OP_RD_LINKS;
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                op         = OP_REM_LINK;
                ring_next  = rem_ring;
                state_next = rem_state;
            end
            S_APP_CHK:
            begin
                if (sel_zero)
                begin
                    op         = OP_APP_ONE;
                    state_next = S_DONE;
                end
                else
                begin
                    op         = OP_APP_TAIL;
                    state_next = S_APP_HEAD;
                end
            end
            S_APP_HEAD:
            begin
                op         = OP_APP_HEAD;
                state_next = S_DONE;
            end
            S_CHR_WALK:
            begin
                if (stat.sleep_zero)
                begin
                    op         = OP_CHR_HIT;
                    ring_next  = RING_WAIT;
                    state_next = S_REM_RD;
                end
                else if (stat.walk_last)
                begin
                    st_next    = ST_NONE_WOKEN;
                    state_next = S_DONE;
                end
                else
                begin
                    op = OP_CHR_STEP;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    op         = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ring_reg  <= RING_READY;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            ring_reg  <= ring_next;
            st_reg    <= st_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign cmd      = '{op: op, ring: ring_reg, st: st_reg};

endmodule

[design/rrts_dp.sv]
// ============================================================================
// rrts_dp
// Datapath of the scheduler: slot busy flags, ring heads, tails and counts,
// the link and sleep RAMs, scan counter and the result word register.
// ============================================================================
module rrts_dp #(
    parameter int SLOT_COUNT = 32,
    parameter int SLEEP_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rrts_pkg::dp_cmd_t                    cmd,
    output rrts_pkg::dp_stat_t                   stat,
    input  logic [rrts_pkg::MODE_W-1:0]          s_tuser,
    input  logic [rrts_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [rrts_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import rrts_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int SUM_W  = CNT_W + 1;

    // Ring registers.
    logic [SLOT_W-1:0]     r_head_reg, r_head_next, r_tail_reg, r_tail_next;
    logic [CNT_W-1:0]      r_cnt_reg, r_cnt_next;
    logic [SLOT_W-1:0]     w_head_reg, w_head_next, w_tail_reg, w_tail_next;
    logic [CNT_W-1:0]      w_cnt_reg, w_cnt_next;
    logic [SLOT_COUNT-1:0] busy_reg, busy_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    // Working and result registers.
    logic [SLOT_W-1:0]     cur_slot_reg, cur_slot_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [SLEEP_BITS-1:0] sv_reg, sv_next;
    logic [CHAR_W-1:0]     ch_reg, ch_next;
    logic [SLOT_OUT_W-1:0] created_reg, created_next;
    logic [SLOT_OUT_W-1:0] woken_reg, woken_next;
    logic [CHAR_W-1:0]     wchar_reg, wchar_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Selected ring view.
    logic [SLOT_W-1:0]     sel_head, sel_tail, rg_head, rg_tail;
    logic [CNT_W-1:0]      sel_cnt, rg_cnt;
    logic                  ring_upd;

    // RAM ports.
    logic                  nl_we, pl_we, sl_we;
    logic [SLOT_W-1:0]     nl_waddr, pl_waddr, sl_waddr;
    logic [SLOT_W-1:0]     nl_wdata, pl_wdata;
    logic [SLEEP_BITS-1:0] sl_wdata;
    logic [SLOT_W-1:0]     nl_raddr, pl_raddr, sl_raddr;
    logic [SLOT_W-1:0]     nl_rdata, pl_rdata;
    logic [SLEEP_BITS-1:0] sl_rdata;

    logic [SLOT_OUT_W-1:0] run_slot;

    rrts_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_next_link (
        .clk   (clk),
        .we    (nl_we),
        .waddr (nl_waddr),
        .wdata (nl_wdata),
        .raddr (nl_raddr),
        .rdata (nl_rdata)
    );

    rrts_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_prev_link (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .raddr (pl_raddr),
        .rdata (pl_rdata)
    );

    rrts_ram #(.WIDTH(SLEEP_BITS), .DEPTH(SLOT_COUNT)) u_sleep (
        .clk   (clk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    always_comb
    begin
        stat.mode       = mode_reg;
        stat.ready_zero = (r_cnt_reg == '0);
        stat.ready_one  = (r_cnt_reg == CNT_W'(1));
        stat.wait_zero  = (w_cnt_reg == '0);
        stat.wait_one   = (w_cnt_reg == CNT_W'(1));
        stat.free_hit   = !busy_reg[idx_reg];
        stat.free_last  = (idx_reg == SLOT_W'(SLOT_COUNT - 1));
        stat.sleep_zero = (sl_rdata == '0);
        stat.walk_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == w_cnt_reg);
        stat.out_busy   = m_tvalid_reg && !m_tready;
    end

    assign run_slot = (r_cnt_reg != '0) ? SLOT_OUT_W'(r_head_reg) : '0;

    always_comb
    begin
        r_head_next   = r_head_reg;
        r_tail_next   = r_tail_reg;
        r_cnt_next    = r_cnt_reg;
        w_head_next   = w_head_reg;
        w_tail_next   = w_tail_reg;
        w_cnt_next    = w_cnt_reg;
        busy_next     = busy_reg;
        cur_slot_next = cur_slot_reg;
        idx_next      = idx_reg;
        mode_next     = mode_reg;
        sv_next       = sv_reg;
        ch_next       = ch_reg;
        created_next  = created_reg;
        woken_next    = woken_reg;
        wchar_next    = wchar_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        sel_head = (cmd.ring == RING_READY) ? r_head_reg : w_head_reg;
        sel_tail = (cmd.ring == RING_READY) ? r_tail_reg : w_tail_reg;
        sel_cnt  = (cmd.ring == RING_READY) ? r_cnt_reg  : w_cnt_reg;
        rg_head  = sel_head;
        rg_tail  = sel_tail;
        rg_cnt   = sel_cnt;
        ring_upd = 1'b0;

        nl_we    = 1'b0;
        pl_we    = 1'b0;
        sl_we    = 1'b0;
        nl_waddr = cur_slot_reg;
        pl_waddr = cur_slot_reg;
        sl_waddr = cur_slot_reg;
        nl_wdata = cur_slot_reg;
        pl_wdata = cur_slot_reg;
        sl_wdata = '0;
        nl_raddr = cur_slot_reg;
        pl_raddr = cur_slot_reg;
        sl_raddr = cur_slot_reg;

        case (cmd.op)
            OP_ACCEPT:
            begin
                mode_next    = s_tuser;
                sv_next      = SLEEP_BITS'(s_tdata[SLEEP_IN_W-1:0]);
                ch_next      = s_tdata[SLEEP_IN_W +: CHAR_W];
                created_next = '0;
                woken_next   = '0;
                wchar_next   = '0;
            end
            OP_RD_RHEAD:
            begin
                nl_raddr = r_head_reg;
            end
            OP_TICK_ADV:
            begin
                // The old head becomes the tail of the rotated ring.
                r_tail_next = r_head_reg;
                r_head_next = nl_rdata;
            end
            OP_CRT_CLEAR:
            begin
                idx_next = '0;
            end
            OP_CRT_SCAN:
            begin
                idx_next = idx_reg + SLOT_W'(1);
                if (!busy_reg[idx_reg])
                begin
                    cur_slot_next      = idx_reg;
                    busy_next[idx_reg] = 1'b1;
                    sl_we              = 1'b1;
                    sl_waddr           = idx_reg;
                    sl_wdata           = '0;
                    created_next       = SLOT_OUT_W'(idx_reg);
                end
            end
            OP_KILL_TAKE:
            begin
                cur_slot_next         = r_head_reg;
                busy_next[r_head_reg] = 1'b0;
            end
            OP_WAIT_TAKE:
            begin
                cur_slot_next = r_head_reg;
                sl_we         = 1'b1;
                sl_waddr      = r_head_reg;
                sl_wdata      = sv_reg;
            end
            OP_RD_LINKS:
            begin
                nl_raddr = cur_slot_reg;
                pl_raddr = cur_slot_reg;
            end
            OP_REM_CLR:
            begin
                ring_upd = 1'b1;
                rg_head  = '0;
                rg_tail  = '0;
                rg_cnt   = '0;
            end
            OP_REM_LINK:
            begin
                // Neighbors of the leaving slot are on the link read ports.
                pl_we    = 1'b1;
                pl_waddr = nl_rdata;
                pl_wdata = pl_rdata;
                nl_we    = 1'b1;
                nl_waddr = pl_rdata;
                nl_wdata = nl_rdata;
                ring_upd = 1'b1;
                if (sel_head == cur_slot_reg)
                begin
                    rg_head = nl_rdata;
                end
                if ((sel_head == cur_slot_reg) || (nl_rdata == sel_head))
                begin
                    rg_tail = pl_rdata;
                end
                rg_cnt = sel_cnt - CNT_W'(1);
            end
            OP_APP_ONE:
            begin
                nl_we    = 1'b1;
                pl_we    = 1'b1;
                ring_upd = 1'b1;
                rg_head  = cur_slot_reg;
                rg_tail  = cur_slot_reg;
                rg_cnt   = sel_cnt + CNT_W'(1);
            end
            OP_APP_TAIL:
            begin
                nl_we    = 1'b1;
                nl_waddr = sel_tail;
                nl_wdata = cur_slot_reg;
                pl_we    = 1'b1;
                pl_waddr = cur_slot_reg;
                pl_wdata = sel_tail;
            end
            OP_APP_HEAD:
            begin
                nl_we    = 1'b1;
                nl_waddr = cur_slot_reg;
                nl_wdata = sel_head;
                pl_we    = 1'b1;
                pl_waddr = sel_head;
                pl_wdata = cur_slot_reg;
                ring_upd = 1'b1;
                rg_tail  = cur_slot_reg;
                rg_cnt   = sel_cnt + CNT_W'(1);
            end
            OP_CHR_START:
            begin
                nl_raddr      = w_head_reg;
                sl_raddr      = w_head_reg;
                cur_slot_next = w_head_reg;
                idx_next      = '0;
            end
            OP_CHR_STEP:
            begin
                // Follow the link that was read along with the sleep value.
                nl_raddr      = nl_rdata;
                sl_raddr      = nl_rdata;
                cur_slot_next = nl_rdata;
                idx_next      = idx_reg + SLOT_W'(1);
            end
            OP_CHR_HIT:
            begin
                sl_we      = 1'b1;
                sl_wdata   = '0;
                woken_next = SLOT_OUT_W'(cur_slot_reg);
                wchar_next = ch_reg;
            end
            OP_FINISH:
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {2'b00, cmd.st,
                                 CNT_OUT_W'(w_cnt_reg), CNT_OUT_W'(r_cnt_reg),
                                 wchar_reg, woken_reg, created_reg,
                                 (r_cnt_reg != '0), run_slot};
            end
            default:
            begin
            end
        endcase

        if (ring_upd)
        begin
            if (cmd.ring == RING_READY)
            begin
                r_head_next = rg_head;
                r_tail_next = rg_tail;
                r_cnt_next  = rg_cnt;
            end
            else
            begin
                w_head_next = rg_head;
                w_tail_next = rg_tail;
                w_cnt_next  = rg_cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_head_reg   <= '0;
            r_tail_reg   <= '0;
            r_cnt_reg    <= '0;
            w_head_reg   <= '0;
            w_tail_reg   <= '0;
            w_cnt_reg    <= '0;
            busy_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            r_head_reg   <= r_head_next;
            r_tail_reg   <= r_tail_next;
            r_cnt_reg    <= r_cnt_next;
            w_head_reg   <= w_head_next;
            w_tail_reg   <= w_tail_next;
            w_cnt_reg    <= w_cnt_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_slot_reg <= cur_slot_next;
        idx_reg      <= idx_next;
        mode_reg     <= mode_next;
        sv_reg       <= sv_next;
        ch_reg       <= ch_next;
        created_reg  <= created_next;
        woken_reg    <= woken_next;
        wchar_reg    <= wchar_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A slot lives in at most one ring, so the two counts never exceed the pool.
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ((SUM_W'(r_cnt_reg) + SUM_W'(w_cnt_reg)) <= SUM_W'(SLOT_COUNT)))
        else $error("ring counts exceed the slot pool");

    a_ready_single: assert property (@(posedge clk) disable iff (!rst_n)
        (r_cnt_reg <= CNT_W'(1)) |-> (r_head_reg == r_tail_reg))
        else $error("ready ring of one slot has head and tail apart");

    a_wait_single: assert property (@(posedge clk) disable iff (!rst_n)
        (w_cnt_reg <= CNT_W'(1)) |-> (w_head_reg == w_tail_reg))
        else $error("waiting ring of one slot has head and tail apart");

    a_create_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == OP_CRT_SCAN) && stat.free_hit) |=> busy_reg[cur_slot_reg])
        else $error("created slot not marked busy");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH) |-> !(m_tvalid_reg && !m_tready))
        else $error("result word overwritten while stalled");

endmodule

[design/round_robin_thread_slot_scheduler.sv]
// ============================================================================
// round_robin_thread_slot_scheduler
// Thread slot manager with a circular ready ring and a waiting ring.
// ============================================================================
// Usage:
//   Request words enter on the s_ channel: s_tuser carries the operation
//   (tick, create, kill, wait, character) and s_tdata the sleep value and
//   the received character. Each request yields exactly one result word on
//   the m_ channel with the running slot, created and woken slots, the ring
//   counts and a status code.
//   Requests are handled one at a time. Create runs a free-slot scan that
//   tests one busy flag per cycle. A character runs a walk of the waiting
//   ring that reads one sleep value and link per cycle from the RAMs. Once
//   the result is raised, the controller returns to idle and takes the next
//   request.
//   The result sits in an output register, so a new request is accepted while
//   the previous result still waits; a stalled m_tready holds the result and
//   stops the following request only at its final step.
//   Reset clears all busy flags and both rings; no thread runs afterwards.
// ============================================================================
module round_robin_thread_slot_scheduler #(
    parameter int SLOT_COUNT = 32,
    parameter int SLEEP_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: sleep_value[31:0], in_char[39:32]
    input  logic [rrts_pkg::IN_DATA_W-1:0]      s_tdata,
    // s_tuser: mode[2:0]
    input  logic [rrts_pkg::MODE_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: running_slot[4:0], running_valid[5], created_slot[10:6],
    //          woken_slot[15:11], woken_char[23:16], ready_total[29:24],
    //          waiting_total[35:30], status[37:36], zero[39:38]
    output logic [rrts_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import rrts_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rrts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrts_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLEEP_BITS (SLEEP_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
